/* rtl/xrp_pkg.sv */
// Package for the XMODEM page-pairing receiver.
// Protocol byte values, reply and end codes, and the types shared across stages.
// No dependencies.
`default_nettype none

package xrp_pkg;

   localparam logic [7:0]  BYTE_SOH   = 8'h01;
   localparam logic [7:0]  BYTE_EOT   = 8'h04;
   localparam logic [7:0]  POS_SOH    = 8'd1;
   localparam logic [7:0]  POS_NUM    = 8'd2;
   localparam logic [7:0]  POS_CPL    = 8'd3;
   localparam logic [7:0]  POS_DATA   = 8'd4;
   localparam logic [7:0]  POS_DLAST  = 8'd131;
   localparam logic [7:0]  LAST_POS   = 8'd133;
   localparam logic [15:0] PKT_FIRST  = 16'd1;

   localparam logic        ACT_START  = 1'b0;

   localparam logic [1:0]  REPLY_NONE = 2'd0;
   localparam logic [1:0]  REPLY_ACK  = 2'd1;
   localparam logic [1:0]  REPLY_EOT  = 2'd2;

   localparam logic [1:0]  END_NONE   = 2'd0;
   localparam logic [1:0]  END_EOT    = 2'd1;
   localparam logic [1:0]  END_ABORT  = 2'd2;

   typedef struct packed {
      logic       valid;
      logic       action;
      logic [7:0] rx_byte;
   } item_type;

   typedef struct packed {
      logic [1:0]  reply_code;
      logic        data_valid;
      logic [7:0]  data_offset;
      logic [7:0]  data_value;
      logic        commit_valid;
      logic [14:0] commit_page;
      logic [1:0]  session_end;
   } result_type;

endpackage

`default_nettype wire

/* rtl/xrp_req_if.sv */
// Request channel interface: valid/ready handshake with action and received byte.
// Standalone; no package dependency.
`default_nettype none

interface xrp_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] rx_byte;

   modport source (output valid, output action, output rx_byte, input ready);
   modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

`default_nettype wire

/* rtl/xrp_rsp_if.sv */
// Response channel interface: valid/ready handshake with reply, payload and commit fields.
// Standalone; no package dependency.
`default_nettype none

interface xrp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  reply_code;
   logic        data_valid;
   logic [7:0]  data_offset;
   logic [7:0]  data_value;
   logic        commit_valid;
   logic [14:0] commit_page;
   logic [1:0]  session_end;

   modport source (output valid, output reply_code, output data_valid, output data_offset,
                   output data_value, output commit_valid, output commit_page,
                   output session_end, input ready);
   modport sink   (input valid, input reply_code, input data_valid, input data_offset,
                   input data_value, input commit_valid, input commit_page,
                   input session_end, output ready);
endinterface

`default_nettype wire

/* rtl/xrp_in_stage.sv */
// Input register of the receiver: captures one request per cycle while it is empty or advance is high.
// Depends on xrp_pkg and xrp_req_if.
`default_nettype none

module xrp_in_stage import xrp_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   xrp_req_if.sink   req_chan,
   input  wire logic advance,
   output item_type  item
);

   logic       valid_ff, valid_in;
   logic       action_ff;
   logic [7:0] rx_byte_ff;
   logic       take;

   assign req_chan.ready = !valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;
   assign valid_in       = take ? 1'b1 : (advance ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         action_ff  <= req_chan.action;
         rx_byte_ff <= req_chan.rx_byte;
      end
   end

   assign item.valid   = valid_ff;
   assign item.action  = action_ff;
   assign item.rx_byte = rx_byte_ff;

endmodule

`default_nettype wire

/* rtl/xrp_core.sv */
// Session state and per-byte decode of the receiver.
// Depends on xrp_pkg.
`default_nettype none

module xrp_core import xrp_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire item_type item,
   input  wire logic     advance,
   output result_type    result
);

   logic        in_session_ff, in_session_in;
   logic [7:0]  byte_position_ff, byte_position_in;
   logic [15:0] packet_number_ff, packet_number_in;
   logic [7:0]  pos;
   logic [6:0]  pos_data;
   logic [7:0]  num;
   logic        fire;

   assign fire     = item.valid && advance;
   assign pos      = byte_position_ff + 8'd1;
   assign pos_data = pos[6:0] - POS_DATA[6:0];
   assign num      = packet_number_ff[7:0];

   always_comb begin
      in_session_in    = in_session_ff;
      byte_position_in = byte_position_ff;
      packet_number_in = packet_number_ff;
      result           = '0;
      if (item.action == ACT_START) begin
         in_session_in     = 1'b1;
         byte_position_in  = '0;
         packet_number_in  = PKT_FIRST;
         result.reply_code = REPLY_ACK;
      end else if (in_session_ff) begin
         byte_position_in = pos;
         if (pos == POS_SOH) begin
            if (item.rx_byte == BYTE_EOT) begin
               result.reply_code  = REPLY_EOT;
               result.session_end = END_EOT;
               in_session_in      = 1'b0;
               byte_position_in   = '0;
            end else if (item.rx_byte != BYTE_SOH) begin
               result.session_end = END_ABORT;
               in_session_in      = 1'b0;
               byte_position_in   = '0;
            end
         end else if (pos == POS_NUM) begin
            if (item.rx_byte != num) begin
               result.session_end = END_ABORT;
               in_session_in      = 1'b0;
               byte_position_in   = '0;
            end
         end else if (pos == POS_CPL) begin
            if (item.rx_byte != ~num) begin
               result.session_end = END_ABORT;
               in_session_in      = 1'b0;
               byte_position_in   = '0;
            end
         end else if (pos >= POS_DATA && pos <= POS_DLAST) begin
            result.data_valid  = 1'b1;
            result.data_offset = {~packet_number_ff[0], pos_data};
            result.data_value  = item.rx_byte;
         end else if (pos >= LAST_POS) begin
            result.reply_code = REPLY_ACK;
            if (!packet_number_ff[0]) begin
               result.commit_valid = 1'b1;
               result.commit_page  = packet_number_ff[15:1] - 15'd1;
            end
            packet_number_in = packet_number_ff + 16'd1;
            byte_position_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_session_ff    <= 1'b0;
         byte_position_ff <= '0;
         packet_number_ff <= PKT_FIRST;
      end else if (fire) begin
         in_session_ff    <= in_session_in;
         byte_position_ff <= byte_position_in;
         packet_number_ff <= packet_number_in;
      end
   end

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      byte_position_ff < LAST_POS)
      else $error("byte position past end of packet");

   a_commit_acks: assert property (@(posedge clock) disable iff (reset)
      fire && result.commit_valid |-> result.reply_code == REPLY_ACK)
      else $error("commit without ACK");

   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      fire && result.session_end != END_NONE |=> !in_session_ff && byte_position_ff == '0)
      else $error("session still open after end");

   a_data_quiet: assert property (@(posedge clock) disable iff (reset)
      fire && result.data_valid |-> result.reply_code == REPLY_NONE
                                    && result.session_end == END_NONE)
      else $error("payload byte with reply or end");

   a_idle_byte: assert property (@(posedge clock) disable iff (reset)
      fire && item.action != ACT_START && !in_session_ff |=> $stable(packet_number_ff)
                                                            && !in_session_ff)
      else $error("idle byte changed state");

endmodule

`default_nettype wire

/* rtl/xrp_out_stage.sv */
// Result register of the receiver: holds one response until the sink takes it.
// Depends on xrp_pkg and xrp_rsp_if.
`default_nettype none

module xrp_out_stage import xrp_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   input  wire result_type result,
   output logic            advance,
   xrp_rsp_if.source       rsp_chan
);

   logic       valid_ff, valid_in;
   result_type result_ff;

   assign advance  = !valid_ff || rsp_chan.ready;
   assign valid_in = advance ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         result_ff <= result;
      end
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.reply_code   = result_ff.reply_code;
   assign rsp_chan.data_valid   = result_ff.data_valid;
   assign rsp_chan.data_offset  = result_ff.data_offset;
   assign rsp_chan.data_value   = result_ff.data_value;
   assign rsp_chan.commit_valid = result_ff.commit_valid;
   assign rsp_chan.commit_page  = result_ff.commit_page;
   assign rsp_chan.session_end  = result_ff.session_end;

endmodule

`default_nettype wire

/* rtl/xmodem_receiver_page_pairing.sv */
// XMODEM receiver with page pairing: top level.
// Depends on xrp_pkg, xrp_req_if, xrp_rsp_if, xrp_in_stage, xrp_core, xrp_out_stage.
//
// Usage:
//   req_chan carries one request per handshake: action 0 opens (or restarts) a
//   session and answers ACK; action 1 delivers one received serial byte.
//   rsp_chan returns exactly one response per request, in order: the reply
//   byte code, a payload byte with its page-buffer offset, a flash page
//   commit for even packets, and the session end reason.
//   Path: a request taken into the input register passes through the decode
//   and is then captured by the result register, which drives rsp_chan.
//   Throughput: one request per cycle while rsp_chan does not stall; the packet
//   header compare and the position counter update sit between the two registers.
//   When rsp_chan stalls, the result register holds and the input register
//   takes one more request; req_chan.ready then drops until rsp_chan drains.
//   Reset (synchronous, active high) empties both registers, closes the
//   session, clears the byte position and sets the packet number to 1.
`default_nettype none

module xmodem_receiver_page_pairing import xrp_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   xrp_req_if.sink   req_chan,
   xrp_rsp_if.source rsp_chan
);

   item_type   item;
   result_type result;
   logic       advance;

   xrp_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .advance  (advance),
      .item     (item)
   );

   xrp_core u_core (
      .clock   (clock),
      .reset   (reset),
      .item    (item),
      .advance (advance),
      .result  (result)
   );

   xrp_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .in_valid (item.valid),
      .result   (result),
      .advance  (advance),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

/* dv/xrp_checker.sv */
// Checker for the XMODEM page-pairing receiver: watches the request and response
// channels, predicts each response and compares it field by field.
// Depends on xrp_pkg.
`default_nettype none

module xrp_checker import xrp_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  wire logic       req_action,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire result_type rsp_result,
   output int              mismatch_count,
   output int              replies_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0] HALF_PAGE_BASE = 8'd128;

   logic        session_open;
   logic [7:0]  rx_position;
   logic [15:0] packet_num;
   result_type  pending_replies[$];
   result_type  oldest_reply;

   function automatic result_type receive_request(input logic act, input logic [7:0] b);
      result_type  r;
      logic [7:0]  pos;
      logic [7:0]  num;
      logic [15:0] page;
      r = '0;
      num = packet_num[7:0];
      if (act == ACT_START) begin
         session_open = 1'b1;
         rx_position = '0;
         packet_num = PKT_FIRST;
         r.reply_code = REPLY_ACK;
      end else if (session_open) begin
         pos = rx_position + 8'd1;
         rx_position = pos;
         if (pos == POS_SOH) begin
            if (b == BYTE_EOT) begin
               r.reply_code = REPLY_EOT;
               r.session_end = END_EOT;
            end else if (b != BYTE_SOH) begin
               r.session_end = END_ABORT;
            end
         end else if (pos == POS_NUM) begin
            if (b != num) r.session_end = END_ABORT;
         end else if (pos == POS_CPL) begin
            if (b != ~num) r.session_end = END_ABORT;
         end else if (pos >= POS_DATA && pos <= POS_DLAST) begin
            r.data_valid = 1'b1;
            r.data_offset = (packet_num[0] ? 8'd0 : HALF_PAGE_BASE) + (pos - POS_DATA);
            r.data_value = b;
         end else if (pos >= LAST_POS) begin
            r.reply_code = REPLY_ACK;
            if (!packet_num[0]) begin
               page = {1'b0, packet_num[15:1]} - 16'd1;
               r.commit_valid = 1'b1;
               r.commit_page = page[14:0];
            end
            packet_num = packet_num + 16'd1;
            rx_position = '0;
         end
         if (r.session_end != END_NONE) begin
            session_open = 1'b0;
            rx_position = '0;
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string field, input logic [14:0] got,
                              input logic [14:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d expected %0d", field, got, want));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pending_replies.delete();
         session_open = 1'b0;
         rx_position = '0;
         packet_num = PKT_FIRST;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_replies.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               oldest_reply = pending_replies.pop_front();
               check_field("reply_code", rsp_result.reply_code, oldest_reply.reply_code);
               check_field("data_valid", rsp_result.data_valid, oldest_reply.data_valid);
               check_field("data_offset", rsp_result.data_offset, oldest_reply.data_offset);
               check_field("data_value", rsp_result.data_value, oldest_reply.data_value);
               check_field("commit_valid", rsp_result.commit_valid, oldest_reply.commit_valid);
               check_field("commit_page", rsp_result.commit_page, oldest_reply.commit_page);
               check_field("session_end", rsp_result.session_end, oldest_reply.session_end);
            end
         end
         if (req_valid && req_ready)
            pending_replies.push_back(receive_request(req_action, req_rx_byte));
      end
      replies_owed <= pending_replies.size();
   end

endmodule

`default_nettype wire

/* dv/tb.sv */
// Testbench top for the XMODEM page-pairing receiver: clock, reset, request
// stimulus with bursts and pauses, response stalls, watchdog and verdict.
// Depends on xrp_pkg, xrp_req_if, xrp_rsp_if, xrp_checker and the block.
`default_nettype none

module tb import xrp_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic ACT_BYTE      = 1'b1;
   localparam int   REQUEST_GOAL  = 1500;
   localparam int   LONG_HOLD     = 300;
   localparam int   STALL_LIMIT   = 3000;
   localparam int   DRAIN_CYCLES  = 6;

   typedef enum logic [2:0] {CUT_NONE, CUT_SOH, CUT_NUM, CUT_CPL, CUT_TRUNCATE} cut_type;

   logic       clock;
   logic       reset;
   int         mismatch_count;
   int         replies_owed;
   int         requests_sent;
   int         burst_left;
   int         idle_cycles;
   bit         hold_asked;
   result_type rsp_seen;

   xrp_req_if req_chan();
   xrp_rsp_if rsp_chan();

   xmodem_receiver_page_pairing u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   assign rsp_seen = {rsp_chan.reply_code, rsp_chan.data_valid, rsp_chan.data_offset,
                      rsp_chan.data_value, rsp_chan.commit_valid, rsp_chan.commit_page,
                      rsp_chan.session_end};

   xrp_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .req_action     (req_chan.action),
      .req_rx_byte    (req_chan.rx_byte),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_result     (rsp_seen),
      .mismatch_count (mismatch_count),
      .replies_owed   (replies_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic send_request(input logic act, input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid   <= 1'b1;
      req_chan.action  <= act;
      req_chan.rx_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      requests_sent++;
   endtask

   task automatic wait_all_replies();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (replies_owed != 0) @(posedge clock);
   endtask

   task automatic send_packet(input logic [15:0] pnum, input cut_type cut);
      logic [7:0] num;
      logic [7:0] b;
      int         stop_at;
      num = pnum[7:0];
      stop_at = $urandom_range(1, LAST_POS);
      for (int pos = 1; pos <= LAST_POS; pos++) begin
         if (cut == CUT_TRUNCATE && pos == stop_at) return;
         if (pos == POS_SOH) b = BYTE_SOH;
         else if (pos == POS_NUM) b = num;
         else if (pos == POS_CPL) b = ~num;
         else b = 8'($urandom_range(0, 255));
         if ((cut == CUT_SOH && pos == POS_SOH) || (cut == CUT_NUM && pos == POS_NUM) ||
             (cut == CUT_CPL && pos == POS_CPL)) begin
            send_request(ACT_BYTE, b ^ 8'($urandom_range(1, 255)));
            return;
         end
         send_request(ACT_BYTE, b);
      end
   endtask

   // response stalls: random stretches of full rate, light and heavy stalling, and one long hold
   initial begin
      int  stretch_left;
      int  ready_pct;
      bit  hold_served;
      stretch_left = 0;
      ready_pct = 100;
      hold_served = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asked && !hold_served) begin
            hold_served = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         if (stretch_left == 0) begin
            stretch_left = $urandom_range(5, 60);
            case ($urandom_range(0, 2))
               0: ready_pct = 100;
               1: ready_pct = 60;
               default: ready_pct = 20;
            endcase
         end
         stretch_left--;
         rsp_chan.ready <= ($urandom_range(1, 100) <= ready_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int      npackets;
      int      pick;
      cut_type cut;
      req_chan.valid = 1'b0;
      req_chan.action = ACT_START;
      req_chan.rx_byte = '0;
      reset = 1'b1;
      requests_sent = 0;
      burst_left = 0;
      hold_asked = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // bytes while idle, EOT end, header aborts, restart while open
      send_request(ACT_BYTE, 8'hFF);
      send_request(ACT_BYTE, 8'h00);
      send_request(ACT_START, 8'hFF);
      send_request(ACT_BYTE, BYTE_EOT);
      send_request(ACT_BYTE, BYTE_SOH);
      send_request(ACT_START, 8'h00);
      send_request(ACT_BYTE, 8'hFF);
      send_request(ACT_START, 8'h00);
      send_request(ACT_BYTE, BYTE_SOH);
      send_request(ACT_BYTE, 8'h02);
      send_request(ACT_START, 8'h00);
      send_request(ACT_BYTE, BYTE_SOH);
      send_request(ACT_BYTE, 8'h01);
      send_request(ACT_BYTE, 8'h01);
      send_request(ACT_START, 8'h00);
      send_request(ACT_START, 8'h00);
      send_request(ACT_BYTE, BYTE_SOH);
      send_request(ACT_BYTE, 8'h01);
      send_request(ACT_BYTE, 8'hFE);
      send_request(ACT_BYTE, 8'h00);
      send_request(ACT_BYTE, 8'hFF);
      send_request(ACT_START, 8'h55);
      send_request(ACT_BYTE, 8'hAA);
      wait_all_replies();

      hold_asked = 1'b1;
      while (requests_sent < REQUEST_GOAL) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            repeat ($urandom_range(1, 4))
               send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
         end else begin
            send_request(ACT_START, 8'($urandom_range(0, 255)));
            npackets = $urandom_range(1, 4);
            cut = CUT_NONE;
            for (int p = 1; p <= npackets && cut == CUT_NONE; p++) begin
               case ($urandom_range(0, 19))
                  0: cut = CUT_SOH;
                  1: cut = CUT_NUM;
                  2: cut = CUT_CPL;
                  3: cut = CUT_TRUNCATE;
                  default: cut = CUT_NONE;
               endcase
               send_packet(16'(p), cut);
            end
            if (cut == CUT_NONE && $urandom_range(0, 9) < 6)
               send_request(ACT_BYTE, BYTE_EOT);
         end
         if ($urandom_range(0, 9) == 0) wait_all_replies();
      end

      wait_all_replies();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire
